FILE: hw/rtl/assert_macros.svh
// Concurrent assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define CTPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ctps assertion failed");

// Same, on the usual clk_i / rst_ni pair.
`define CTPS_ASSERT_DEF(lbl, prop) \
  `CTPS_ASSERT(lbl, clk_i, rst_ni, prop)

`endif

FILE: hw/rtl/ctps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ctps_pkg;

  localparam int unsigned MaxVertices = 1024;

  localparam int unsigned FuncW     = 2;
  localparam int unsigned CoordW    = 20;
  localparam int unsigned CoefW     = 24;
  localparam int unsigned CoefIdxW  = 4;
  localparam int unsigned NumCoef   = 12;
  localparam int unsigned IdxOutW   = 10;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned VertexW   = 3 * CoordW;

  // datapath widths
  localparam int unsigned FracW     = 16;
  localparam int unsigned ProdW     = CoefW + CoordW;     // one coefficient times one coord
  localparam int unsigned AccW      = ProdW + 2;          // three products plus rounding
  localparam int unsigned DiffW     = 32;                 // transformed minus query coord
  localparam int unsigned SqW       = 2 * DiffW;          // squared distance

  localparam int RoundQ16 = 32768;

  localparam logic [FuncW-1:0] FuncClear  = 2'd0;
  localparam logic [FuncW-1:0] FuncAppend = 2'd1;
  localparam logic [FuncW-1:0] FuncCoef   = 2'd2;
  localparam logic [FuncW-1:0] FuncQuery  = 2'd3;

  localparam logic [StatusW-1:0] StatusOk    = 2'd0;
  localparam logic [StatusW-1:0] StatusFull  = 2'd1;
  localparam logic [StatusW-1:0] StatusEmpty = 2'd2;

  localparam logic signed [CoefW-1:0] OneQ16 = 24'sh010000;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef coord_t [2:0] vec_t;           // element 0 is x
  typedef logic signed [CoefW-1:0] coef_t;
  typedef coef_t [NumCoef-1:0] matrix_t; // row*4+col, col 3 is translation

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  function automatic matrix_t identity_matrix();
    matrix_t m;
    m     = '0;
    m[0]  = OneQ16;
    m[5]  = OneQ16;
    m[10] = OneQ16;
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ctps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ctps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ctps_xform.sv
`timescale 1ns / 1ps
`default_nettype none

// Transform pipeline: vertex -> matrix products -> row sums -> difference to
// the query point -> magnitude -> square -> squared distance.
module ctps_xform #(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctps_pkg::tag_t        tag_i,
  input  wire logic [IDX_W-1:0]      idx_i,
  input  wire ctps_pkg::vec_t        vertex_i,
  input  wire ctps_pkg::matrix_t     matrix_i,
  input  wire ctps_pkg::vec_t        point_i,
  output ctps_pkg::tag_t             tag_o,
  output logic [IDX_W-1:0]           idx_o,
  output logic [ctps_pkg::SqW-1:0]   dist_o
);

  localparam int unsigned NumStages = 6;

  ctps_pkg::tag_t   tag_pipe_q [NumStages];
  logic [IDX_W-1:0] idx_pipe_q [NumStages];

  logic signed [ctps_pkg::ProdW-1:0] prod_d [3][3];
  logic signed [ctps_pkg::ProdW-1:0] prod_q [3][3];
  logic signed [ctps_pkg::AccW-1:0]  acc_d  [3];
  logic signed [ctps_pkg::AccW-1:0]  acc_q  [3];
  logic signed [ctps_pkg::DiffW-1:0] diff_d [3];
  logic signed [ctps_pkg::DiffW-1:0] diff_q [3];
  logic [ctps_pkg::DiffW-1:0]        mag_d  [3];
  logic [ctps_pkg::DiffW-1:0]        mag_q  [3];
  logic [ctps_pkg::SqW-1:0]          sq_d   [3];
  logic [ctps_pkg::SqW-1:0]          sq_q   [3];
  logic [ctps_pkg::SqW-1:0]          dist_d;
  logic [ctps_pkg::SqW-1:0]          dist_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(matrix_i[r*4+c]) * $signed(vertex_i[c]);
      end
      acc_d[r] = ctps_pkg::AccW'(prod_q[r][0]) + ctps_pkg::AccW'(prod_q[r][1])
               + ctps_pkg::AccW'(prod_q[r][2]) + ctps_pkg::AccW'(ctps_pkg::RoundQ16);
      // arithmetic shift of the rounded sum floors, giving round half up
      diff_d[r] = ctps_pkg::DiffW'($signed(acc_q[r][ctps_pkg::AccW-1:ctps_pkg::FracW]))
                + ctps_pkg::DiffW'($signed(matrix_i[r*4+3]))
                - ctps_pkg::DiffW'($signed(point_i[r]));
      mag_d[r]  = diff_q[r][ctps_pkg::DiffW-1] ? ctps_pkg::DiffW'(-diff_q[r])
                                                : ctps_pkg::DiffW'(diff_q[r]);
      sq_d[r]   = mag_q[r] * mag_q[r];
    end
    dist_d = sq_q[0] + sq_q[1] + sq_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumStages; k++) begin
        tag_pipe_q[k] <= '0;
      end
    end else begin
      tag_pipe_q[0] <= tag_i;
      for (int k = 1; k < NumStages; k++) begin
        tag_pipe_q[k] <= tag_pipe_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_pipe_q[0] <= idx_i;
    for (int k = 1; k < NumStages; k++) begin
      idx_pipe_q[k] <= idx_pipe_q[k-1];
    end
    prod_q <= prod_d;
    acc_q  <= acc_d;
    diff_q <= diff_d;
    mag_q  <= mag_d;
    sq_q   <= sq_d;
    dist_q <= dist_d;
  end

  assign tag_o  = tag_pipe_q[NumStages-1];
  assign idx_o  = idx_pipe_q[NumStages-1];
  assign dist_o = dist_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ctps_best.sv
`timescale 1ns / 1ps
`default_nettype none

// Running minimum over the squared distances of one query.
module ctps_best #(
  parameter int unsigned IDX_W = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire ctps_pkg::tag_t           tag_i,
  input  wire logic [IDX_W-1:0]         idx_i,
  input  wire logic [ctps_pkg::SqW-1:0] dist_i,
  output logic                          done_o,
  output logic [IDX_W-1:0]              best_idx_o
);

  logic                     have_q, have_d;
  logic                     done_q, done_d;
  logic [ctps_pkg::SqW-1:0] best_q, best_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic                     take;

  // strict compare keeps the lower index on a tie
  assign take = tag_i.valid && (!have_q || (dist_i < best_q));

  always_comb begin
    have_d = have_q;
    best_d = best_q;
    idx_d  = idx_q;
    done_d = tag_i.valid && tag_i.last;
    priority if (start_i) begin
      have_d = 1'b0;
    end else if (tag_i.valid) begin
      have_d = 1'b1;
    end else begin
      have_d = have_q;
    end
    if (take) begin
      best_d = dist_i;
      idx_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      have_q <= have_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    idx_q  <= idx_d;
  end

  assign done_o     = done_q;
  assign best_idx_o = idx_q;

endmodule

`default_nettype wire

FILE: hw/rtl/closest_transformed_point_search.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid_i/in_stall_o | func, coord_x/y/z, coef_index, coef_value
// output  | out       | out_valid_o/out_stall_i | closest_index, status
//
// Clear, append and coefficient writes place their result in the output
// register the cycle after the transfer.
// During a query the vertex memory read port delivers one vertex per cycle
// into the transform pipeline.
// Reset empties the store and loads the identity matrix; no clearing pass.
// Input stalls while a query runs and while a result waits on a stalled output.
module closest_transformed_point_search #(
  parameter int unsigned MAX_VERTICES = ctps_pkg::MaxVertices
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [ctps_pkg::FuncW-1:0]         func_i,
  input  wire logic signed [ctps_pkg::CoordW-1:0] coord_x_i,
  input  wire logic signed [ctps_pkg::CoordW-1:0] coord_y_i,
  input  wire logic signed [ctps_pkg::CoordW-1:0] coord_z_i,
  input  wire logic [ctps_pkg::CoefIdxW-1:0]      coef_index_i,
  input  wire logic signed [ctps_pkg::CoefW-1:0]  coef_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [ctps_pkg::IdxOutW-1:0]            closest_index_o,
  output logic [ctps_pkg::StatusW-1:0]            status_o
);

  localparam int unsigned AddrW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_VERTICES + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StHold  = 2'd3;

  logic [1:0]                     state_q, state_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [AddrW-1:0]               scan_q, scan_d;
  logic                           out_valid_q, out_valid_d;
  logic [ctps_pkg::IdxOutW-1:0]   out_idx_q, out_idx_d;
  logic [ctps_pkg::StatusW-1:0]   out_status_q, out_status_d;
  ctps_pkg::matrix_t              matrix_q;
  ctps_pkg::vec_t                 point_q;
  ctps_pkg::tag_t                 rd_tag_q, rd_tag_d;
  logic [AddrW-1:0]               rd_idx_q;

  logic                           out_free, in_xfer, start, ram_we;
  logic [CntW-1:0]                count_m1;
  logic [AddrW-1:0]               last_addr;
  logic [ctps_pkg::VertexW-1:0]   ram_wdata, ram_rdata;
  ctps_pkg::vec_t                 rd_vertex;
  ctps_pkg::tag_t                 xf_tag;
  logic [AddrW-1:0]               xf_idx;
  logic [ctps_pkg::SqW-1:0]       xf_dist;
  logic                           best_done;
  logic [AddrW-1:0]               best_idx;
  logic [AddrW+ctps_pkg::IdxOutW-1:0] best_idx_wide;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StIdle) || !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign count_m1      = count_q - CntW'(1);
  assign last_addr     = count_m1[AddrW-1:0];
  assign ram_wdata     = {coord_z_i, coord_y_i, coord_x_i};
  assign rd_vertex     = ram_rdata;
  assign best_idx_wide = {{ctps_pkg::IdxOutW{1'b0}}, best_idx};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_idx_d    = out_idx_q;
    out_status_d = out_status_q;
    rd_tag_d     = '0;
    start        = 1'b0;
    ram_we       = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          out_valid_d  = 1'b1;
          out_idx_d    = '0;
          out_status_d = ctps_pkg::StatusOk;
          unique case (func_i)
            ctps_pkg::FuncClear: begin
              count_d = '0;
            end
            ctps_pkg::FuncAppend: begin
              if (count_q < CntW'(MAX_VERTICES)) begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                out_status_d = ctps_pkg::StatusFull;
              end
            end
            ctps_pkg::FuncCoef: begin
              // matrix register handles the write
            end
            ctps_pkg::FuncQuery: begin
              if (count_q == '0) begin
                out_status_d = ctps_pkg::StatusEmpty;
              end else begin
                out_valid_d = 1'b0;
                scan_d      = '0;
                start       = 1'b1;
                state_d     = StScan;
              end
            end
          endcase
        end
      end
      StScan: begin
        rd_tag_d.valid = 1'b1;
        rd_tag_d.last  = (scan_q == last_addr);
        scan_d         = scan_q + AddrW'(1);
        if (scan_q == last_addr) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        if (best_done) begin
          state_d = StHold;
        end
      end
      StHold: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_idx_d    = best_idx_wide[ctps_pkg::IdxOutW-1:0];
          out_status_d = ctps_pkg::StatusOk;
          state_d      = StIdle;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      rd_tag_q    <= '0;
      matrix_q    <= ctps_pkg::identity_matrix();
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      rd_tag_q    <= rd_tag_d;
      if (in_xfer && (func_i == ctps_pkg::FuncCoef) &&
          (coef_index_i < ctps_pkg::CoefIdxW'(ctps_pkg::NumCoef))) begin
        matrix_q[coef_index_i] <= coef_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    out_idx_q    <= out_idx_d;
    out_status_q <= out_status_d;
    rd_idx_q     <= scan_q;
    if (in_xfer && (func_i == ctps_pkg::FuncQuery)) begin
      point_q <= {coord_z_i, coord_y_i, coord_x_i};
    end
  end

  ctps_ram #(
    .WIDTH (ctps_pkg::VertexW),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (scan_q),
    .rdata_o (ram_rdata)
  );

  ctps_xform #(
    .IDX_W (AddrW)
  ) u_xform (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rd_tag_q),
    .idx_i    (rd_idx_q),
    .vertex_i (rd_vertex),
    .matrix_i (matrix_q),
    .point_i  (point_q),
    .tag_o    (xf_tag),
    .idx_o    (xf_idx),
    .dist_o   (xf_dist)
  );

  ctps_best #(
    .IDX_W (AddrW)
  ) u_best (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .tag_i      (xf_tag),
    .idx_i      (xf_idx),
    .dist_i     (xf_dist),
    .done_o     (best_done),
    .best_idx_o (best_idx)
  );

  assign out_valid_o     = out_valid_q;
  assign closest_index_o = out_idx_q;
  assign status_o        = out_status_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ctps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module ctps_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_stall_o,
  input wire logic [ctps_pkg::FuncW-1:0]   func_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_stall_i,
  input wire logic [ctps_pkg::IdxOutW-1:0] closest_index_o,
  input wire logic [ctps_pkg::StatusW-1:0] status_o
);

  logic in_xfer;
  logic clear_xfer;
  logic query_xfer;
  logic other_xfer;
  logic out_held;

  assign in_xfer    = in_valid_i && !in_stall_o;
  assign clear_xfer = in_xfer && (func_i == ctps_pkg::FuncClear);
  assign query_xfer = in_xfer && (func_i == ctps_pkg::FuncQuery);
  assign other_xfer = in_xfer && (func_i != ctps_pkg::FuncQuery);
  assign out_held   = out_valid_o && out_stall_i;

  // a stalled result holds
  `CTPS_ASSERT_DEF(a_out_hold, out_held |=> out_valid_o && $stable({closest_index_o, status_o}))

  // single result register: no transfer in while a result is stuck
  `CTPS_ASSERT_DEF(a_in_blocked, out_held |-> in_stall_o)

  // non-query items answer in the next cycle with index zero
  `CTPS_ASSERT_DEF(a_nonquery_next, other_xfer |=> out_valid_o && (closest_index_o == '0))

  // a query right after a clear sees an empty store
  `CTPS_ASSERT_DEF(a_clear_query, clear_xfer ##1 query_xfer |=> (status_o == ctps_pkg::StatusEmpty))

endmodule

bind closest_transformed_point_search ctps_checker u_ctps_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .func_i          (func_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .closest_index_o (closest_index_o),
  .status_o        (status_o)
);

`default_nettype wire

FILE: verif/ctps_tb_pkg.sv
`timescale 1ns / 1ps

package ctps_tb_pkg;
  import ctps_pkg::*;

  typedef struct packed {
    logic [IdxOutW-1:0] index;
    logic [StatusW-1:0] status;
  } answer_t;

  // Mirror of the vertex store and the affine matrix; every accepted item
  // queues the answer the block owes for it.
  class closest_point_tracker;
    logic [VertexW-1:0] verts [MaxVertices];
    int unsigned        vertex_total;
    coef_t              mat [NumCoef];
    answer_t            expected_answers [$];
    int unsigned        errors;

    function new();
      vertex_total = 0;
      errors       = 0;
      for (int i = 0; i < NumCoef; i++) mat[i] = '0;
      mat[0]  = OneQ16;
      mat[5]  = OneQ16;
      mat[10] = OneQ16;
    endfunction

    function coord_t stored_coord(int unsigned i, int unsigned c);
      return coord_t'(verts[i][c*CoordW +: CoordW]);
    endfunction

    // World-space coordinate r of stored vertex i, round half up on Q.16
    function longint mapped_coord(int unsigned i, int unsigned r);
      longint acc;
      acc = 0;
      for (int c = 0; c < 3; c++) begin
        acc += longint'(mat[r*4+c]) * longint'(stored_coord(i, c));
      end
      return ((acc + RoundQ16) >>> FracW) + longint'(mat[r*4+3]);
    endfunction

    function int unsigned pending();
      return expected_answers.size();
    endfunction

    function void note_item(logic [FuncW-1:0] f, coord_t x, coord_t y, coord_t z,
                            logic [CoefIdxW-1:0] ci, coef_t cv);
      answer_t           ans;
      longint unsigned   best;
      longint unsigned   dsq;
      longint            d;
      longint            pr;
      ans  = '0;
      best = 0;
      case (f)
        FuncClear: begin
          vertex_total = 0;
        end
        FuncAppend: begin
          if (vertex_total < MaxVertices) begin
            verts[vertex_total] = {z, y, x};
            vertex_total++;
          end else begin
            ans.status = StatusFull;
          end
        end
        FuncCoef: begin
          if (ci < NumCoef) mat[ci] = cv;
        end
        default: begin
          if (vertex_total == 0) begin
            ans.status = StatusEmpty;
          end else begin
            for (int unsigned i = 0; i < vertex_total; i++) begin
              dsq = 0;
              for (int r = 0; r < 3; r++) begin
                pr = (r == 0) ? x : (r == 1) ? y : z;
                d  = mapped_coord(i, r) - pr;
                if (d < 0) d = -d;
                dsq += longint'(unsigned'(d)) * longint'(unsigned'(d));
              end
              // strict compare keeps the lower index on a tie
              if (i == 0 || dsq < best) begin
                best      = dsq;
                ans.index = IdxOutW'(i);
              end
            end
          end
        end
      endcase
      expected_answers.insert(expected_answers.size(), ans);
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [IdxOutW-1:0] idx, logic [StatusW-1:0] st);
      answer_t want;
      if (expected_answers.size() == 0) begin
        report($sformatf("result with nothing pending: index %0d status %0d", idx, st));
      end else begin
        want = expected_answers.pop_front();
        if (idx !== want.index)
          report($sformatf("closest_index %0d, want %0d", idx, want.index));
        if (st !== want.status)
          report($sformatf("status %0d, want %0d", st, want.status));
      end
    endtask
  endclass

endpackage

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ctps_pkg::*;
  import ctps_tb_pkg::*;

  localparam int unsigned RandomItems = 555;
  // must outlast the quiet stretch of a query over a full store
  localparam int unsigned QuietLimit  = 20000;
  localparam int unsigned DrainCycles = 20;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic [FuncW-1:0]         func        = FuncClear;
  coord_t                   coord_x     = '0;
  coord_t                   coord_y     = '0;
  coord_t                   coord_z     = '0;
  logic [CoefIdxW-1:0]      coef_index  = '0;
  coef_t                    coef_value  = '0;
  logic                     out_stall   = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [IdxOutW-1:0]       closest_index;
  logic [StatusW-1:0]       status;

  closest_point_tracker     tracker;
  int unsigned              idle_phase  = 0;
  int unsigned              items_sent  = 0;
  int unsigned              quiet_cycles = 0;

  closest_transformed_point_search #(
    .MAX_VERTICES(MaxVertices)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .coord_x_i      (coord_x),
    .coord_y_i      (coord_y),
    .coord_z_i      (coord_z),
    .coef_index_i   (coef_index),
    .coef_value_i   (coef_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .closest_index_o(closest_index),
    .status_o       (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned tx_idle_pct();
    case (idle_phase)
      0:       return 26;
      1:       return 55;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned rx_idle_pct();
    case (idle_phase)
      0:       return 55;
      1:       return 26;
      default: return 0;
    endcase
  endfunction

  function automatic coef_t identity_coef(int unsigned ci);
    return (ci == 0 || ci == 5 || ci == 10) ? OneQ16 : coef_t'(0);
  endfunction

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t cluster_coord();
    if ($urandom_range(0, 99) < 80) return coord_t'(longint'($urandom_range(0, 4000)) - 2000);
    return any_coord();
  endfunction

  function automatic coord_t jitter(longint c, int unsigned spread);
    return coord_t'(c + longint'($urandom_range(0, 2 * spread)) - longint'(spread));
  endfunction

  // One transfer on the input channel; idle cycles are inserted up front.
  task automatic drive_item(logic [FuncW-1:0] f, coord_t x, coord_t y, coord_t z,
                            logic [CoefIdxW-1:0] ci, coef_t cv);
    while ($urandom_range(0, 99) < tx_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= f;
    coord_x    <= x;
    coord_y    <= y;
    coord_z    <= z;
    coef_index <= ci;
    coef_value <= cv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_item(f, x, y, z, ci, cv);
    items_sent++;
  endtask

  task automatic clear_store();
    drive_item(FuncClear, any_coord(), any_coord(), any_coord(), CoefIdxW'($urandom),
               coef_t'($urandom));
  endtask

  task automatic append_vertex(coord_t x, coord_t y, coord_t z);
    drive_item(FuncAppend, x, y, z, CoefIdxW'($urandom), coef_t'($urandom));
  endtask

  task automatic write_coef(logic [CoefIdxW-1:0] ci, coef_t cv);
    drive_item(FuncCoef, any_coord(), any_coord(), any_coord(), ci, cv);
  endtask

  task automatic query_point(coord_t x, coord_t y, coord_t z);
    drive_item(FuncQuery, x, y, z, CoefIdxW'($urandom), coef_t'($urandom));
  endtask

  // result side: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_result(closest_index, status);
    out_stall <= ($urandom_range(0, 99) < rx_idle_pct());
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    coord_t              hi;
    coord_t              lo;
    logic [CoefIdxW-1:0] ci;
    coef_t               cv;
    int unsigned         pick;
    int unsigned         n;
    int unsigned         idx;
    int unsigned         spread;
    int unsigned         base;

    tracker = new();
    hi      = coord_t'(20'h7FFFF);
    lo      = coord_t'(20'h80000);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, ties, ignored coefficient slots, query after clear
    query_point('0, '0, '0);
    append_vertex(hi, hi, hi);
    append_vertex(lo, lo, lo);
    append_vertex('0, '0, '0);
    query_point('0, '0, '0);
    query_point(hi, hi, hi);
    query_point(lo, lo, lo);
    append_vertex(hi, hi, hi);
    query_point(coord_t'(hi - 1), hi, hi);
    write_coef(CoefIdxW'(13), coef_t'(24'h7FFFFF));
    write_coef(CoefIdxW'(15), coef_t'(24'h800000));
    query_point(lo, lo, lo);
    write_coef(CoefIdxW'(0), coef_t'(24'h7FFFFF));
    write_coef(CoefIdxW'(3), coef_t'(24'h800000));
    write_coef(CoefIdxW'(5), coef_t'(24'h800000));
    write_coef(CoefIdxW'(11), coef_t'(24'h7FFFFF));
    query_point('0, '0, '0);
    query_point(hi, lo, hi);
    clear_store();
    query_point('0, '0, '0);
    write_coef(CoefIdxW'(0), identity_coef(0));
    write_coef(CoefIdxW'(3), identity_coef(3));
    write_coef(CoefIdxW'(5), identity_coef(5));
    write_coef(CoefIdxW'(11), identity_coef(11));
    clear_store();

    // random mix: build small sets, tweak the matrix, query near stored points
    base = items_sent;
    while (items_sent - base < RandomItems) begin
      idle_phase = ((items_sent - base) * 3) / RandomItems;
      pick = $urandom_range(0, 99);
      if (tracker.vertex_total == 0 || tracker.vertex_total > 150 || pick < 8) begin
        if ($urandom_range(0, 99) < 80) clear_store();
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        for (int unsigned k = 0; k < n; k++) begin
          if (tracker.vertex_total != 0 && $urandom_range(0, 99) < 15) begin
            // duplicate vertex forces a tie
            idx = $urandom_range(0, tracker.vertex_total - 1);
            append_vertex(tracker.stored_coord(idx, 0), tracker.stored_coord(idx, 1),
                          tracker.stored_coord(idx, 2));
          end else if ($urandom_range(0, 99) < 20) begin
            append_vertex(any_coord(), any_coord(), any_coord());
          end else begin
            append_vertex(cluster_coord(), cluster_coord(), cluster_coord());
          end
        end
      end else if (pick < 18) begin
        ci = ($urandom_range(0, 9) == 0) ? CoefIdxW'($urandom_range(12, 15))
                                         : CoefIdxW'($urandom_range(0, 11));
        n  = $urandom_range(0, 99);
        if (n < 30) cv = coef_t'($urandom);
        else if (n < 60)
          cv = coef_t'(longint'(identity_coef(ci)) + longint'($urandom_range(0, 16000)) - 8000);
        else if (n < 80) cv = identity_coef(ci);
        else cv = coef_t'(longint'($urandom_range(0, 2000)) - 1000);
        write_coef(ci, cv);
      end else if (pick < 20) begin
        for (int unsigned j = 0; j < NumCoef; j++) write_coef(CoefIdxW'(j), identity_coef(j));
      end else if (pick < 26) begin
        append_vertex(cluster_coord(), cluster_coord(), cluster_coord());
      end else if (pick < 29) begin
        clear_store();
        query_point(any_coord(), any_coord(), any_coord());
      end else if (pick < 70) begin
        idx    = $urandom_range(0, tracker.vertex_total - 1);
        spread = ($urandom_range(0, 3) == 0) ? 300 : $urandom_range(0, 3);
        query_point(jitter(tracker.mapped_coord(idx, 0), spread),
                    jitter(tracker.mapped_coord(idx, 1), spread),
                    jitter(tracker.mapped_coord(idx, 2), spread));
      end else if (pick < 85) begin
        query_point(cluster_coord(), cluster_coord(), cluster_coord());
      end else begin
        query_point(any_coord(), any_coord(), any_coord());
      end
    end

    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/ctps_pkg.sv
hw/rtl/ctps_ram.sv
hw/rtl/ctps_xform.sv
hw/rtl/ctps_best.sv
hw/rtl/closest_transformed_point_search.sv
hw/rtl/ctps_checker.sv
verif/ctps_tb_pkg.sv
verif/tb_top.sv
